// File: rtl/core/crr_pkg.sv
// shared types, constants and helper functions of the cops and robbers solver
package crr_pkg;

  localparam int MAX_NODES = 16;
  localparam int MAX_TEAM  = 3;
  localparam int POS_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int KCNT_W    = 2;
  localparam int SA_W      = POS_W * (MAX_TEAM + 1);
  localparam int CFG_CAP_1 = MAX_NODES;
  localparam int CFG_CAP_2 = CFG_CAP_1 * (MAX_NODES + 1) / 2;
  localparam int CFG_CAP_3 = CFG_CAP_2 * (MAX_NODES + 2) / 3;
  localparam int CFG_CAP_4 = CFG_CAP_3 * (MAX_NODES + 3) / 4;
  localparam int CFG_CAP   = (MAX_TEAM <= 1) ? CFG_CAP_1 :
                             (MAX_TEAM == 2) ? CFG_CAP_2 :
                             (MAX_TEAM == 3) ? CFG_CAP_3 : CFG_CAP_4;
  localparam int QDEPTH    = 2 * CFG_CAP * MAX_NODES;
  localparam int QP_W      = $clog2(QDEPTH + 1);

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [POS_W:0]       wpos_t;
  typedef logic [MAX_NODES-1:0] mask_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [KCNT_W-1:0]    kcnt_t;
  typedef logic [SA_W-1:0]      saddr_t;
  typedef logic [QP_W-1:0]      qptr_t;
  typedef pos_t  [MAX_TEAM-1:0] team_t;
  typedef mask_t [MAX_TEAM-1:0] tmask_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_SOLVE = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_COP_COUNT  = 1'b1;

  typedef struct packed {
    logic ctw;
    logic rtw;
    cnt_t cnt;
  } st_word_t;

  typedef struct packed {
    logic   rob;
    saddr_t addr;
  } qent_t;

  typedef struct packed {
    logic add;
    logic clear;
    pos_t a;
    pos_t b;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic win;
    pos_t pos;
    logic last;
  } res_t;

  typedef struct packed {
    logic  done;
    team_t team;
  } tstep_t;

  typedef struct packed {
    logic hit;
    pos_t pos;
  } nbit_t;

  function automatic mask_t onehot(pos_t p);
    return mask_t'(1) << p;
  endfunction

  function automatic mask_t live_mask(cnt_t n);
    logic [MAX_NODES:0] full;
    full = ((MAX_NODES+1)'(1) << n) - (MAX_NODES+1)'(1);
    return full[MAX_NODES-1:0];
  endfunction

  function automatic pos_t lowbit(mask_t m);
    pos_t res;
    res = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (m[i]) res = pos_t'(i);
    end
    return res;
  endfunction

  function automatic cnt_t popcnt(mask_t m);
    cnt_t s;
    s = '0;
    for (int i = 0; i < MAX_NODES; i++) s = s + cnt_t'(m[i]);
    return s;
  endfunction

  // first set bit strictly above v
  function automatic nbit_t next_above(mask_t m, pos_t v);
    mask_t hi;
    nbit_t res;
    hi = m & ~((mask_t'(2) << v) - mask_t'(1));
    res.hit = |hi;
    res.pos = lowbit(hi);
    return res;
  endfunction

  function automatic saddr_t st_addr(team_t t, pos_t r);
    return {t, r};
  endfunction

  // next sorted team in lexicographic order, unused digits stay zero
  function automatic tstep_t team_next(team_t d, cnt_t n, kcnt_t k);
    tstep_t res;
    logic   found;
    pos_t   top;
    pos_t   bump;
    res.team = d;
    found = 1'b0;
    top = pos_t'(n - cnt_t'(1));
    bump = '0;
    for (int p = MAX_TEAM - 1; p >= 0; p--) begin
      if (!found && p < int'(k) && d[p] != top) begin
        found = 1'b1;
        bump = d[p] + pos_t'(1);
        for (int i = 0; i < MAX_TEAM; i++) begin
          if (i >= p && i < int'(k)) res.team[i] = bump;
        end
      end
    end
    res.done = !found;
    return res;
  endfunction

  // sort the active cop positions, unused slots come out as zero at the end
  function automatic team_t sort_moves(team_t v, kcnt_t k);
    wpos_t w [MAX_TEAM];
    wpos_t tmp;
    team_t res;
    for (int i = 0; i < MAX_TEAM; i++) begin
      w[i] = (i < int'(k)) ? {1'b0, v[i]} : wpos_t'(MAX_NODES);
    end
    for (int a = 0; a < MAX_TEAM - 1; a++) begin
      for (int b = 0; b < MAX_TEAM - 1 - a; b++) begin
        if (w[b] > w[b+1]) begin
          tmp = w[b];
          w[b] = w[b+1];
          w[b+1] = tmp;
        end
      end
    end
    for (int i = 0; i < MAX_TEAM; i++) begin
      res[i] = w[i][POS_W] ? '0 : w[i][POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/crr_adj.sv
// adjacency store of the graph, one neighbor mask per node
module crr_adj import crr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  edge_req_t req,
  input  pos_t      rd_addr,
  output mask_t     rd_row
);

  mask_t adj_r [MAX_NODES];

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      for (int i = 0; i < MAX_NODES; i++) adj_r[i] <= '0;
    end else if (req.add && req.a != req.b) begin
      adj_r[req.a] <= adj_r[req.a] | onehot(req.b);
      adj_r[req.b] <= adj_r[req.b] | onehot(req.a);
    end
  end

  assign rd_row = adj_r[rd_addr];

endmodule

// File: rtl/core/crr_solver.sv
// retrograde solver: state memory, win queue and the sequencer around them
module crr_solver import crr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  cnt_t  n_in,
  input  kcnt_t k_in,
  output pos_t  adj_addr,
  input  mask_t adj_row,
  input  logic  res_free,
  output res_t  res,
  output logic  busy
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_INIT      = 13'b0000000000010,
    S_INIT_PUSH = 13'b0000000000100,
    S_POP_RD    = 13'b0000000001000,
    S_POP_WAIT  = 13'b0000000010000,
    S_LOADC     = 13'b0000000100000,
    S_CMV_RD    = 13'b0000001000000,
    S_CMV_WR    = 13'b0000010000000,
    S_RMV_RD    = 13'b0000100000000,
    S_RMV_WR    = 13'b0001000000000,
    S_SCAN_RD   = 13'b0010000000000,
    S_SCAN_CHK  = 13'b0100000000000,
    S_EMIT      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   n_r, n_nxt;
  kcnt_t  k_r, k_nxt;
  team_t  d_r, d_nxt;
  pos_t   r_r, r_nxt;
  team_t  cur_t_r, cur_t_nxt;
  pos_t   cur_r_r, cur_r_nxt;
  tmask_t mask_r, mask_nxt;
  team_t  v_r, v_nxt;
  kcnt_t  j_r, j_nxt;
  pos_t   x_r, x_nxt;
  mask_t  rmask_r, rmask_nxt;
  saddr_t wa_r, wa_nxt;
  qptr_t  head_r, head_nxt;
  qptr_t  tail_r, tail_nxt;
  kcnt_t  e_r, e_nxt;
  logic   win_r, win_nxt;

  st_word_t st_mem [2**SA_W];
  st_word_t st_q_r;
  qent_t    q_mem [QDEPTH];
  qent_t    q_q_r;

  logic     st_re, st_we, q_re, q_we;
  saddr_t   st_raddr, st_waddr;
  st_word_t st_wdata;
  qent_t    q_wdata;

  mask_t  live_row;
  tstep_t tnext;
  logic   r_last;
  logic   caught;
  nbit_t  nb_c [MAX_TEAM];
  nbit_t  rnb;
  saddr_t cur_addr;
  cnt_t   dec_cnt;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_q_r <= st_mem[st_raddr];
    if (q_we) q_mem[tail_r[QP_W-1:0]] <= q_wdata;
    if (q_re) q_q_r <= q_mem[head_r[QP_W-1:0]];
  end

  always_comb begin
    case (state_r)
      S_INIT:     adj_addr = r_r;
      S_LOADC:    adj_addr = cur_t_r[j_r];
      S_POP_WAIT: adj_addr = q_q_r.addr[POS_W-1:0];
      default:    adj_addr = r_r;
    endcase
  end

  assign live_row = adj_row & live_mask(n_r) & ~onehot(adj_addr);
  assign tnext    = team_next(d_r, n_r, k_r);
  assign r_last   = ({1'b0, r_r} == n_r - cnt_t'(1));
  assign cur_addr = st_addr(d_r, r_r);
  assign rnb      = next_above(rmask_r, x_r);
  assign dec_cnt  = (st_q_r.cnt != '0) ? st_q_r.cnt - cnt_t'(1) : '0;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    caught = 1'b0;
    for (int i = 0; i < MAX_TEAM; i++) begin
      if (i < int'(k_r) && d_r[i] == r_r) caught = 1'b1;
      nb_c[i] = next_above(mask_r[i], v_r[i]);
    end
  end

  always_comb begin
    logic found;
    mask_t m;
    state_nxt = state_r;
    n_nxt = n_r;
    k_nxt = k_r;
    d_nxt = d_r;
    r_nxt = r_r;
    cur_t_nxt = cur_t_r;
    cur_r_nxt = cur_r_r;
    mask_nxt = mask_r;
    v_nxt = v_r;
    j_nxt = j_r;
    x_nxt = x_r;
    rmask_nxt = rmask_r;
    wa_nxt = wa_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    e_nxt = e_r;
    win_nxt = win_r;
    st_re = 1'b0;
    st_raddr = cur_addr;
    st_we = 1'b0;
    st_waddr = wa_r;
    st_wdata = st_q_r;
    q_re = 1'b0;
    q_we = 1'b0;
    q_wdata = '{rob: 1'b0, addr: wa_r};
    res = '0;
    found = 1'b0;
    m = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (n_in == '0) n_nxt = cnt_t'(1);
          else if (n_in > cnt_t'(MAX_NODES)) n_nxt = cnt_t'(MAX_NODES);
          else n_nxt = n_in;
          if (k_in == '0) k_nxt = kcnt_t'(1);
          else if (k_in > kcnt_t'(MAX_TEAM)) k_nxt = kcnt_t'(MAX_TEAM);
          else k_nxt = k_in;
          d_nxt = '0;
          r_nxt = '0;
          head_nxt = '0;
          tail_nxt = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT, S_INIT_PUSH: begin
        if (state_r == S_INIT) begin
          st_we = 1'b1;
          st_waddr = cur_addr;
          st_wdata = '{ctw: caught, rtw: caught,
                       cnt: caught ? cnt_t'(0) : popcnt(live_row) + cnt_t'(1)};
        end
        if (state_r == S_INIT && caught) begin
          // capture: queue the cop-turn win now, the robber-turn win next cycle
          q_we = 1'b1;
          q_wdata = '{rob: 1'b0, addr: cur_addr};
          tail_nxt = tail_r + qptr_t'(1);
          wa_nxt = cur_addr;
          state_nxt = S_INIT_PUSH;
        end else begin
          if (state_r == S_INIT_PUSH) begin
            q_we = 1'b1;
            q_wdata = '{rob: 1'b1, addr: wa_r};
            tail_nxt = tail_r + qptr_t'(1);
          end
          state_nxt = S_INIT;
          if (r_last) begin
            r_nxt = '0;
            if (tnext.done) state_nxt = S_POP_RD;
            else d_nxt = tnext.team;
          end else begin
            r_nxt = r_r + pos_t'(1);
          end
        end
      end
      S_POP_RD: begin
        if (head_r == tail_r) begin
          d_nxt = '0;
          r_nxt = '0;
          state_nxt = S_SCAN_RD;
        end else begin
          q_re = 1'b1;
          head_nxt = head_r + qptr_t'(1);
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cur_t_nxt = team_t'(q_q_r.addr[SA_W-1:POS_W]);
        cur_r_nxt = q_q_r.addr[POS_W-1:0];
        if (q_q_r.rob) begin
          for (int i = 0; i < MAX_TEAM; i++) mask_nxt[i] = mask_t'(1);
          v_nxt = '0;
          j_nxt = '0;
          state_nxt = S_LOADC;
        end else begin
          m = live_row | onehot(adj_addr);
          rmask_nxt = m;
          x_nxt = lowbit(m);
          state_nxt = S_RMV_RD;
        end
      end
      S_LOADC: begin
        m = live_row | onehot(adj_addr);
        mask_nxt[j_r] = m;
        v_nxt[j_r] = lowbit(m);
        if (j_r == k_r - kcnt_t'(1)) state_nxt = S_CMV_RD;
        else j_nxt = j_r + kcnt_t'(1);
      end
      S_CMV_RD: begin
        st_re = 1'b1;
        st_raddr = st_addr(sort_moves(v_r, k_r), cur_r_r);
        wa_nxt = st_raddr;
        state_nxt = S_CMV_WR;
      end
      S_CMV_WR: begin
        if (!st_q_r.ctw) begin
          st_we = 1'b1;
          st_wdata = '{ctw: 1'b1, rtw: st_q_r.rtw, cnt: st_q_r.cnt};
          q_we = 1'b1;
          q_wdata = '{rob: 1'b0, addr: wa_r};
          tail_nxt = tail_r + qptr_t'(1);
        end
        // odometer over the team moves
        for (int p = MAX_TEAM - 1; p >= 0; p--) begin
          if (!found && p < int'(k_r) && nb_c[p].hit) begin
            found = 1'b1;
            v_nxt[p] = nb_c[p].pos;
            for (int i = 0; i < MAX_TEAM; i++) begin
              if (i > p && i < int'(k_r)) v_nxt[i] = lowbit(mask_r[i]);
            end
          end
        end
        state_nxt = found ? S_CMV_RD : S_POP_RD;
      end
      S_RMV_RD: begin
        st_re = 1'b1;
        st_raddr = st_addr(cur_t_r, x_r);
        wa_nxt = st_raddr;
        state_nxt = S_RMV_WR;
      end
      S_RMV_WR: begin
        if (!st_q_r.rtw) begin
          st_we = 1'b1;
          st_wdata = '{ctw: st_q_r.ctw, rtw: (dec_cnt == '0), cnt: dec_cnt};
          if (dec_cnt == '0) begin
            q_we = 1'b1;
            q_wdata = '{rob: 1'b1, addr: wa_r};
            tail_nxt = tail_r + qptr_t'(1);
          end
        end
        if (rnb.hit) begin
          x_nxt = rnb.pos;
          state_nxt = S_RMV_RD;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_SCAN_RD: begin
        st_re = 1'b1;
        st_raddr = cur_addr;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        e_nxt = '0;
        if (!st_q_r.ctw) begin
          r_nxt = '0;
          if (tnext.done) begin
            win_nxt = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            d_nxt = tnext.team;
            state_nxt = S_SCAN_RD;
          end
        end else if (r_last) begin
          win_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          r_nxt = r_r + pos_t'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        if (res_free) begin
          res.valid = 1'b1;
          res.win = win_r;
          res.pos = win_r ? d_r[e_r] : '0;
          res.last = !win_r || (e_r == k_r - kcnt_t'(1));
          if (res.last) state_nxt = S_IDLE;
          else e_nxt = e_r + kcnt_t'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
    n_r <= n_nxt;
    k_r <= k_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
    cur_t_r <= cur_t_nxt;
    cur_r_r <= cur_r_nxt;
    mask_r <= mask_nxt;
    v_r <= v_nxt;
    j_r <= j_nxt;
    x_r <= x_nxt;
    rmask_r <= rmask_nxt;
    wa_r <= wa_nxt;
    e_r <= e_nxt;
    win_r <= win_nxt;
  end

endmodule

// File: rtl/core/cops_robbers_retrograde_solver_core.sv
// top level of the cops and robbers solver: config registers, input decode, result register
//
// input channel (in_valid/in_ready): mode add edge, solve, or clear graph.
// add and clear items give no result; mode 3 is dropped.
// a solve item is taken at once and in_ready stays low until its verdict has
// been handed to the result register. a solve makes an initial sweep over all
// sorted cop teams times robber nodes, queuing both turn wins on a capture, then
// drains the win queue: a robber-turn entry loads the cop neighbor rows, one per
// cop, and then walks the team moves; a cop-turn entry walks the robber
// predecessors. once the queue runs empty it scans the teams, reading each
// state in turn.
// result channel (out_valid/out_ready): one transfer per cop of the first
// winning team in lexicographic order, or one loss transfer; out_last marks
// the final one. results leave at one per cycle; a stalled receiver holds the
// result register and pauses the solver, and the next input item may be
// taken while the final result still waits.
// cfg_we writes node_count (index 0) or cop_count (index 1).
// reset clears the graph and sets node_count 16 and cop_count 1; no memory
// clearing pass is needed since a solve writes every entry before reading it.
module cops_robbers_retrograde_solver_core import crr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  pos_t       in_node_a,
  input  pos_t       in_node_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_cops_win,
  output pos_t       out_cop_position,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  cnt_t       cfg_wdata
);

  cnt_t      node_count_r;
  kcnt_t     cop_count_r;
  logic      out_valid_r;
  logic      out_win_r;
  pos_t      out_pos_r;
  logic      out_last_r;
  logic      in_xfer;
  logic      busy;
  logic      res_free;
  res_t      sres;
  edge_req_t ereq;
  pos_t      adj_addr;
  mask_t     adj_row;

  assign in_xfer    = in_valid && in_ready;
  assign in_ready   = !busy;
  assign res_free   = !out_valid_r || out_ready;
  assign ereq.add   = in_xfer && (in_mode == MODE_ADD);
  assign ereq.clear = in_xfer && (in_mode == MODE_CLEAR);
  assign ereq.a     = in_node_a;
  assign ereq.b     = in_node_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= cnt_t'(MAX_NODES);
      cop_count_r <= kcnt_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        CFG_COP_COUNT:  cop_count_r <= cfg_wdata[KCNT_W-1:0];
        default: ;
      endcase
    end
  end

  crr_adj u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ereq),
    .rd_addr (adj_addr),
    .rd_row  (adj_row)
  );

  crr_solver u_solver (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer && (in_mode == MODE_SOLVE)),
    .n_in     (node_count_r),
    .k_in     (cop_count_r),
    .adj_addr (adj_addr),
    .adj_row  (adj_row),
    .res_free (res_free),
    .res      (sres),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sres.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (sres.valid) begin
      out_win_r <= sres.win;
      out_pos_r <= sres.pos;
      out_last_r <= sres.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cops_win     = out_win_r;
  assign out_cop_position = out_pos_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  a_solve_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_mode == MODE_SOLVE) |=> !in_ready)
    else $error("input taken while a solve runs");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    sres.valid |-> (!out_valid_r || out_ready))
    else $error("solver result overwrote a waiting result");

  a_loss_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cops_win) |-> (out_last && out_cop_position == '0))
    else $error("loss result not marked last or position not zero");
`endif

endmodule
